### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants for the fourth-order direct-form-I IIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 24;
  localparam int MAX_ORDER_DEF    = 4;

  // Integer bits of a Q4.x coefficient.
  localparam int COEF_INT_BITS = 4;

  localparam int ORDER_WIDTH     = 3;
  localparam int REG_INDEX_WIDTH = 3;

  localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 3'd1;

  localparam logic [REG_INDEX_WIDTH-1:0] REG_ORDER       = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_DIRECT = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_TAP1   = 3'd2;

endpackage

`default_nettype wire

### sv/iir_direct_form1_order4_core.sv
// ----------------------------------------------------------------------------
// iir_direct_form1_order4_core
// Direct-form-I IIR filter of order up to 4 on signed audio samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// filtered sample per sample: the item is held in an input register, and
// once the output register is free the full multiply-accumulate over the input
// and up to four past inputs and outputs, rounding and saturation run as one
// combinational pass into the output register while the past-sample history
// advances. That single pass is the feedback loop that sets the clock rate.
// Coefficients are Q4.20 signed; order 0 uses only the direct term and
// orders above four use all four taps. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iir_direct_form1_order4_core #(
  parameter int SAMPLE_WIDTH = iirdf1_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = iirdf1_pkg::COEF_WIDTH_DEF,
  parameter int MAX_ORDER    = iirdf1_pkg::MAX_ORDER_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [iirdf1_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [2*COEF_WIDTH-1:0]                cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         sample_in,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]              sample_out
);

  import iirdf1_pkg::*;

  localparam logic [COEF_WIDTH-1:0] COEF_ONE =
    COEF_WIDTH'(1) << (COEF_WIDTH - COEF_INT_BITS);

  logic [ORDER_WIDTH-1:0]          order;
  logic signed [COEF_WIDTH-1:0]    coef_direct;
  logic signed [COEF_WIDTH-1:0]    coef_ff [MAX_ORDER];
  logic signed [COEF_WIDTH-1:0]    coef_fb [MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0]  past_x  [MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0]  past_y  [MAX_ORDER];

  logic                            hold_valid;
  logic signed [SAMPLE_WIDTH-1:0]  hold_sample;
  logic signed [SAMPLE_WIDTH-1:0]  result;
  logic                            out_free;
  logic                            advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      order       <= ORDER_RESET;
      coef_direct <= COEF_ONE;
      for (int k = 0; k < MAX_ORDER; k++) begin
        coef_ff[k] <= '0;
        coef_fb[k] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORDER: begin
          order <= cfg_data[ORDER_WIDTH-1:0];
        end
        REG_COEF_DIRECT: begin
          coef_direct <= cfg_data[COEF_WIDTH-1:0];
        end
        default: begin
          for (int k = 0; k < MAX_ORDER; k++) begin
            if (cfg_index == REG_COEF_TAP1 + REG_INDEX_WIDTH'(k)) begin
              coef_ff[k] <= cfg_data[2*COEF_WIDTH-1:COEF_WIDTH];
              coef_fb[k] <= cfg_data[COEF_WIDTH-1:0];
            end
          end
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_sample <= sample_in;
    end
  end

  iirdf1_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .MAX_ORDER    (MAX_ORDER)
  ) u_mac (
    .order       (order),
    .sample      (hold_sample),
    .coef_direct (coef_direct),
    .coef_ff     (coef_ff),
    .coef_fb     (coef_fb),
    .past_x      (past_x),
    .past_y      (past_y),
    .result      (result)
  );

  // Advance the history as the item moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        past_x[k] <= '0;
        past_y[k] <= '0;
      end
    end else if (advance) begin
      past_x[0] <= hold_sample;
      past_y[0] <= result;
      for (int k = 1; k < MAX_ORDER; k++) begin
        past_x[k] <= past_x[k-1];
        past_y[k] <= past_y[k-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= result;
    end
  end

  `ASSERT_CLK(a_no_overrun, hold_valid && out_valid && !out_ready |-> !in_ready, "input overrun")
  `ASSERT_CLK(a_hist_out, advance |=> out_valid && past_y[0] == sample_out, "history mismatch")
  `ASSERT_CLK_ALWAYS(a_reset_empties, rst |=> !hold_valid && !out_valid, "not empty after reset")

endmodule

`default_nettype wire

### sv/iirdf1_mac.sv
// ----------------------------------------------------------------------------
// iirdf1_mac
// Multiply-accumulate over the current and past samples, round, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_mac #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24,
  parameter int MAX_ORDER    = 4
) (
  input  wire logic [iirdf1_pkg::ORDER_WIDTH-1:0] order,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
  input  wire logic signed [COEF_WIDTH-1:0]       coef_direct,
  input  wire logic signed [COEF_WIDTH-1:0]       coef_ff [MAX_ORDER],
  input  wire logic signed [COEF_WIDTH-1:0]       coef_fb [MAX_ORDER],
  input  wire logic signed [SAMPLE_WIDTH-1:0]     past_x  [MAX_ORDER],
  input  wire logic signed [SAMPLE_WIDTH-1:0]     past_y  [MAX_ORDER],
  output logic signed [SAMPLE_WIDTH-1:0]          result
);

  import iirdf1_pkg::*;

  localparam int PW   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int AW   = PW + 4;
  localparam int FRAC = COEF_WIDTH - COEF_INT_BITS;

  localparam logic signed [AW-1:0] Y_MAX =
    {{(AW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN =
    {{(AW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam logic signed [AW-1:0] HALF_LSB = AW'(1) << (FRAC - 1);

  logic signed [PW-1:0] prod_direct;
  logic signed [PW-1:0] prod_ff [MAX_ORDER];
  logic signed [PW-1:0] prod_fb [MAX_ORDER];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rounded;
  logic signed [AW-1:0] shifted;

  always_comb begin
    prod_direct = sample * coef_direct;
    for (int k = 0; k < MAX_ORDER; k++) begin
      prod_ff[k] = past_x[k] * coef_ff[k];
      prod_fb[k] = past_y[k] * coef_fb[k];
    end
  end

  // Taps beyond the programmed order drop out.
  always_comb begin
    acc = AW'(prod_direct);
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (order > ORDER_WIDTH'(k)) begin
        acc = acc + AW'(prod_ff[k]) - AW'(prod_fb[k]);
      end
    end
    rounded = acc + HALF_LSB;
    shifted = rounded >>> FRAC;
    if (shifted > Y_MAX) begin
      result = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (shifted < Y_MIN) begin
      result = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      result = shifted[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire
